### rtl/core/daily_weather_gapfill_runavg_core_defines.svh
// Assertion macros shared by the gap-fill running-average core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DAILY_WEATHER_GAPFILL_RUNAVG_CORE_DEFINES_SVH
`define DAILY_WEATHER_GAPFILL_RUNAVG_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define DWG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define DWG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/dwg_pkg.sv
// Shared widths, controller states, command/status structs and helpers
// for the gap-fill running-average core. No dependencies.
`default_nettype none

package dwg_pkg;

   localparam int MAX_WINDOW = 32;
   localparam int PTR_W      = $clog2(MAX_WINDOW);
   localparam int NDAYS_W    = $clog2(MAX_WINDOW + 1);

   localparam int RAW_T_W = 14;
   localparam int OUT_T_W = 15;
   localparam int OFF_W   = 12;
   localparam int PPT_W   = 16;
   localparam int GAIN_W  = 16;
   localparam int DAY_W   = 9;
   localparam int WIN_W   = 6;
   localparam int FILL_W  = OUT_T_W + 1;
   localparam int PROD_W  = PPT_W + GAIN_W;
   localparam int SUM_W   = 20;
   localparam int DIV_BITS  = 19;
   localparam int DIV_CNT_W = $clog2(DIV_BITS);

   localparam int TEMP_LIMIT  = 10000;
   localparam int WIN_RESET   = 7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_MEAN,
      ST_SUM,
      ST_DIV_PREP,
      ST_DIVIDE,
      ST_DONE
   } dwg_state_type;

   typedef struct packed {
      logic capture;
      logic fill;
      logic mean;
      logic sum_step;
      logic div_init;
      logic div_step;
      logic load_out;
   } dwg_cmd_type;

   typedef struct packed {
      logic sum_empty;
      logic sum_last;
      logic div_last;
      logic out_free;
   } dwg_sts_type;

   // Clamp a filled temperature to the +/- limit and narrow it
   function automatic logic signed [OUT_T_W-1:0] sat_temp(
      input logic signed [FILL_W-1:0] v
   );
      logic signed [FILL_W-1:0] r;
      begin
         if (v > FILL_W'(TEMP_LIMIT)) begin
            r = FILL_W'(TEMP_LIMIT);
         end else if (v < -FILL_W'(TEMP_LIMIT)) begin
            r = -FILL_W'(TEMP_LIMIT);
         end else begin
            r = v;
         end
         return r[OUT_T_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

### rtl/core/dwg_ctrl.sv
// Sequencing state machine for the gap-fill running-average core.
// Depends on dwg_pkg and the assertion macro header.
`default_nettype none
`include "daily_weather_gapfill_runavg_core_defines.svh"

module dwg_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire dwg_pkg::dwg_sts_type sts,
   output dwg_pkg::dwg_cmd_type     cmd
);
   import dwg_pkg::*;

   dwg_state_type state_ff;
   dwg_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            cmd.mean = 1'b1;
            state_in = sts.sum_empty ? ST_DONE : ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.sum_last) begin
               state_in = ST_DIV_PREP;
            end
         end
         ST_DIV_PREP: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `DWG_ASSERT_NXT(a_accept_fill, clock, reset, req_valid && !req_stall, state_ff == ST_FILL, "accepted word did not start the fill step")
   `DWG_ASSERT_IMP(a_load_free, clock, reset, cmd.load_out, sts.out_free, "result loaded over a word still waiting")
   `DWG_ASSERT_IMP(a_sum_nonempty, clock, reset, state_ff == ST_SUM, !sts.sum_empty, "summing with an empty average window")
   `DWG_ASSERT_NXT(a_prep_divide, clock, reset, state_ff == ST_DIV_PREP, state_ff == ST_DIVIDE, "divider prepared but not started")

endmodule

`default_nettype wire

### rtl/core/dwg_datapath.sv
// Datapath: input capture, gap fill, mean ring, serial sum, bit-serial
// divider, precipitation scaling and the output register. Uses dwg_pkg.
`default_nettype none

module dwg_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire dwg_pkg::dwg_cmd_type               cmd,
   output dwg_pkg::dwg_sts_type                    sts,
   input  wire logic                               csr_wr_en,
   input  wire logic [dwg_pkg::WIN_W-1:0]          csr_wr_data,
   input  wire logic signed [dwg_pkg::RAW_T_W-1:0] req_raw_tmax,
   input  wire logic signed [dwg_pkg::RAW_T_W-1:0] req_raw_tmin,
   input  wire logic [dwg_pkg::PPT_W-1:0]          req_raw_ppt,
   input  wire logic                               req_tmax_absent,
   input  wire logic                               req_tmin_absent,
   input  wire logic                               req_ppt_absent,
   input  wire logic signed [dwg_pkg::OFF_W-1:0]   req_offset_tmax,
   input  wire logic signed [dwg_pkg::OFF_W-1:0]   req_offset_tmin,
   input  wire logic [dwg_pkg::GAIN_W-1:0]         req_precip_gain,
   input  wire logic [dwg_pkg::DAY_W-1:0]          req_day_number,
   input  wire logic                               req_year_start,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [dwg_pkg::OUT_T_W-1:0]      rsp_tmax_out,
   output logic signed [dwg_pkg::OUT_T_W-1:0]      rsp_tmin_out,
   output logic signed [dwg_pkg::OUT_T_W-1:0]      rsp_tmean_out,
   output logic signed [dwg_pkg::OUT_T_W-1:0]      rsp_trun_avg,
   output logic [dwg_pkg::PPT_W-1:0]               rsp_ppt_filled,
   output logic [dwg_pkg::PPT_W-1:0]               rsp_ppt_scaled
);
   import dwg_pkg::*;

   // Configuration
   logic [WIN_W-1:0]   win_cfg_ff;
   logic [NDAYS_W-1:0] win_clamp;
   logic [NDAYS_W-1:0] ndays_calc;

   // Captured word
   logic signed [RAW_T_W-1:0] rtmax_ff, rtmin_ff;
   logic                      tmax_abs_ff, tmin_abs_ff;
   logic signed [OFF_W-1:0]   otmax_ff, otmin_ff;
   logic [PPT_W-1:0]          ppt_ff;
   logic [GAIN_W-1:0]         gain_ff;
   logic [NDAYS_W-1:0]        win_ff;
   logic [NDAYS_W-1:0]        ndays_ff;

   // Filled temperatures; they also serve as yesterday's values
   logic signed [OUT_T_W-1:0] tmax_ff, tmin_ff, tmax_in, tmin_in;
   logic signed [OUT_T_W-1:0] mean_ff, mean_in;
   logic [PROD_W-1:0]         prod_ff;
   logic [PPT_W-1:0]          scaled_ff, scaled_in;

   // Mean ring
   logic signed [OUT_T_W-1:0] ring_ff [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]     ring_vld_ff;
   logic [PTR_W-1:0]          ptr_ff, ptr_in;
   logic [NDAYS_W-1:0]        ptr_inc;

   // Serial sum
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [PTR_W-1:0]          idx_ff;
   logic signed [OUT_T_W-1:0] entry;

   // Bit-serial divider
   logic [NDAYS_W-1:0]   rem_ff, rem_in;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic                 neg_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [NDAYS_W:0]     rem_sh;
   logic [SUM_W-1:0]     sum_mag;
   logic signed [OUT_T_W-1:0] avg;

   logic rsp_valid_ff;

   // Clamp window and pick the number of averaged days
   always_comb begin
      if (win_cfg_ff == '0) begin
         win_clamp = NDAYS_W'(1);
      end else if (NDAYS_W'(win_cfg_ff) > NDAYS_W'(MAX_WINDOW)) begin
         win_clamp = NDAYS_W'(MAX_WINDOW);
      end else begin
         win_clamp = NDAYS_W'(win_cfg_ff);
      end
      if (req_day_number < DAY_W'(win_clamp)) begin
         ndays_calc = req_day_number[NDAYS_W-1:0];
      end else begin
         ndays_calc = win_clamp;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         win_cfg_ff <= WIN_W'(WIN_RESET);
      end else if (csr_wr_en) begin
         win_cfg_ff <= csr_wr_data;
      end
   end

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rtmax_ff    <= req_raw_tmax;
         rtmin_ff    <= req_raw_tmin;
         tmax_abs_ff <= req_tmax_absent;
         tmin_abs_ff <= req_tmin_absent;
         otmax_ff    <= req_offset_tmax;
         otmin_ff    <= req_offset_tmin;
         ppt_ff      <= req_ppt_absent ? '0 : req_raw_ppt;
         gain_ff     <= req_precip_gain;
         win_ff      <= win_clamp;
         ndays_ff    <= ndays_calc;
      end
   end

   // Fill missing values, add offsets, saturate
   always_comb begin
      logic signed [OUT_T_W-1:0] sel_max, sel_min;
      sel_max = tmax_abs_ff ? tmax_ff : OUT_T_W'(rtmax_ff);
      sel_min = tmin_abs_ff ? tmin_ff : OUT_T_W'(rtmin_ff);
      tmax_in = sat_temp(FILL_W'(sel_max) + FILL_W'(otmax_ff));
      tmin_in = sat_temp(FILL_W'(sel_min) + FILL_W'(otmin_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmax_ff <= '0;
         tmin_ff <= '0;
      end else if (cmd.fill) begin
         tmax_ff <= tmax_in;
         tmin_ff <= tmin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         prod_ff <= PROD_W'(ppt_ff) * PROD_W'(gain_ff);
      end
   end

   // Floor mean, scaled precipitation, next ring slot
   always_comb begin
      logic signed [FILL_W-1:0] tsum;
      tsum    = FILL_W'(tmax_ff) + FILL_W'(tmin_ff);
      mean_in = tsum[FILL_W-1:1];
      if (|prod_ff[PROD_W-1:PPT_W+8]) begin
         scaled_in = '1;
      end else begin
         scaled_in = prod_ff[PPT_W+7:8];
      end
      ptr_inc = NDAYS_W'(ptr_ff) + NDAYS_W'(1);
      ptr_in  = (ptr_inc < win_ff) ? ptr_inc[PTR_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.mean) begin
         mean_ff   <= mean_in;
         scaled_ff <= scaled_in;
         ring_ff[ptr_ff] <= mean_in;
      end
   end

   // Ring valid bits and write pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
         ptr_ff      <= '0;
      end else if (cmd.capture && req_year_start) begin
         ring_vld_ff <= '0;
         ptr_ff      <= '0;
      end else if (cmd.mean) begin
         ring_vld_ff[ptr_ff] <= 1'b1;
         ptr_ff              <= ptr_in;
      end
   end

   // Accumulate ring entries, one per cycle
   always_comb begin
      entry  = ring_vld_ff[idx_ff] ? ring_ff[idx_ff] : '0;
      sum_in = sum_ff + SUM_W'(entry);
   end

   always_ff @(posedge clock) begin
      if (cmd.mean) begin
         sum_ff <= '0;
         idx_ff <= '0;
      end else if (cmd.sum_step) begin
         sum_ff <= sum_in;
         idx_ff <= idx_ff + PTR_W'(1);
      end
   end

   // Restoring division of the magnitude, one quotient bit per cycle
   always_comb begin
      sum_mag = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
      rem_sh  = {rem_ff, quo_ff[DIV_BITS-1]};
      if (rem_sh >= (NDAYS_W+1)'(ndays_ff)) begin
         rem_in = NDAYS_W'(rem_sh - (NDAYS_W+1)'(ndays_ff));
         quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
      end else begin
         rem_in = rem_sh[NDAYS_W-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= sum_mag[DIV_BITS-1:0];
         neg_ff <= sum_ff[SUM_W-1];
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
      end
   end

   // Sign the quotient; an empty window averages to zero
   always_comb begin
      if (ndays_ff == '0) begin
         avg = '0;
      end else if (neg_ff) begin
         avg = -quo_ff[OUT_T_W-1:0];
      end else begin
         avg = quo_ff[OUT_T_W-1:0];
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_tmax_out   <= tmax_ff;
         rsp_tmin_out   <= tmin_ff;
         rsp_tmean_out  <= mean_ff;
         rsp_trun_avg   <= avg;
         rsp_ppt_filled <= ppt_ff;
         rsp_ppt_scaled <= scaled_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Status to the controller
   always_comb begin
      sts.sum_empty = (ndays_ff == '0);
      sts.sum_last  = ((NDAYS_W'(idx_ff) + NDAYS_W'(1)) == ndays_ff);
      sts.div_last  = (cnt_ff == DIV_CNT_W'(DIV_BITS - 1));
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

endmodule

`default_nettype wire

### rtl/core/daily_weather_gapfill_runavg_core.sv
// An accepted word steps through the fill, mean, sum, divide-prep, divide and done
// states to rsp_valid; N = min(day, window) days are averaged, and when N is 0 the
// sum and divide are skipped. A new word is taken only once the last is loaded; the
// pace is set by the serial ring sum (one entry a cycle) and 19-step bit-serial divider.
// Reset (synchronous, active high) clears the ring valid bits, pointer, held temperatures,
// window register (to 7) and the output valid.
`default_nettype none

module daily_weather_gapfill_runavg_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [dwg_pkg::WIN_W-1:0]          csr_wr_data,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [dwg_pkg::RAW_T_W-1:0] req_raw_tmax,
   input  wire logic signed [dwg_pkg::RAW_T_W-1:0] req_raw_tmin,
   input  wire logic [dwg_pkg::PPT_W-1:0]          req_raw_ppt,
   input  wire logic                               req_tmax_absent,
   input  wire logic                               req_tmin_absent,
   input  wire logic                               req_ppt_absent,
   input  wire logic signed [dwg_pkg::OFF_W-1:0]   req_offset_tmax,
   input  wire logic signed [dwg_pkg::OFF_W-1:0]   req_offset_tmin,
   input  wire logic [dwg_pkg::GAIN_W-1:0]         req_precip_gain,
   input  wire logic [dwg_pkg::DAY_W-1:0]          req_day_number,
   input  wire logic                               req_year_start,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [dwg_pkg::OUT_T_W-1:0]      rsp_tmax_out,
   output logic signed [dwg_pkg::OUT_T_W-1:0]      rsp_tmin_out,
   output logic signed [dwg_pkg::OUT_T_W-1:0]      rsp_tmean_out,
   output logic signed [dwg_pkg::OUT_T_W-1:0]      rsp_trun_avg,
   output logic [dwg_pkg::PPT_W-1:0]               rsp_ppt_filled,
   output logic [dwg_pkg::PPT_W-1:0]               rsp_ppt_scaled
);
   import dwg_pkg::*;

   dwg_cmd_type cmd;
   dwg_sts_type sts;

   // Sequencer
   dwg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and storage
   dwg_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_raw_tmax    (req_raw_tmax),
      .req_raw_tmin    (req_raw_tmin),
      .req_raw_ppt     (req_raw_ppt),
      .req_tmax_absent (req_tmax_absent),
      .req_tmin_absent (req_tmin_absent),
      .req_ppt_absent  (req_ppt_absent),
      .req_offset_tmax (req_offset_tmax),
      .req_offset_tmin (req_offset_tmin),
      .req_precip_gain (req_precip_gain),
      .req_day_number  (req_day_number),
      .req_year_start  (req_year_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tmax_out    (rsp_tmax_out),
      .rsp_tmin_out    (rsp_tmin_out),
      .rsp_tmean_out   (rsp_tmean_out),
      .rsp_trun_avg    (rsp_trun_avg),
      .rsp_ppt_filled  (rsp_ppt_filled),
      .rsp_ppt_scaled  (rsp_ppt_scaled)
   );

endmodule

`default_nettype wire
